FILE: hw/rtl/cebuf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cebuf_pkg
// Shared types and codes for the cursor edit buffer: event actions, result
// status codes, the packed event and result records.
// ----------------------------------------------------------------------------
package cebuf_pkg;

  // Default store size in bytes
  localparam int STORE_DEPTH_DEF = 128;

  // Event actions
  typedef enum logic [1:0] {
    ACT_INSERT    = 2'd0,
    ACT_BACKSPACE = 2'd1,
    ACT_MOVE      = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // One edit event
  typedef struct packed {
    logic [6:0]        read_index;
    logic signed [8:0] cursor_step;
    logic [7:0]        char_code;
    action_t           action;
  } event_t;

  // One result
  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] cursor_pos;
    logic [7:0] text_length;
    logic [1:0] status;
  } result_t;

endpackage : cebuf_pkg
`default_nettype wire

FILE: hw/rtl/cebuf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cebuf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cebuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : cebuf_ram
`default_nettype wire

FILE: hw/rtl/cebuf_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cebuf_seq
// Edit sequencer: holds length and cursor, walks one pointer through the
// store to shift text a byte per cycle, and drives the store's ports.
// ----------------------------------------------------------------------------
module cebuf_seq #(
  parameter int STORE_DEPTH = cebuf_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Event side
  input  wire logic                           ev_valid,
  output logic                                ev_ready,
  input  wire cebuf_pkg::event_t              ev,
  // Result side
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output cebuf_pkg::result_t                  res,
  // Store ports
  output logic                                ram_we,
  output logic [$clog2(STORE_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                          ram_wdata,
  output logic [$clog2(STORE_DEPTH)-1:0]      ram_raddr,
  input  wire logic [7:0]                     ram_rdata
);

  import cebuf_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LEN_W  = $clog2(STORE_DEPTH + 1);
  localparam int MOV_W  = ((LEN_W > 9) ? LEN_W : 9) + 1;
  localparam int CMP_W  = ((LEN_W > 7) ? LEN_W : 7);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SHIFT  = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_PUT    = 7'b0001000,
    S_RDREQ  = 7'b0010000,
    S_RDWAIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state;
  action_t           op;
  logic [7:0]        ch;
  logic [7:0]        rchar;
  logic [1:0]        status;
  logic [LEN_W-1:0]  fill_len;
  logic [LEN_W-1:0]  cursor;
  logic [LEN_W-1:0]  ptr;
  logic [LEN_W-1:0]  end_ptr;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  // Shared pointer unit: next read address and matching write address
  logic [LEN_W-1:0]  ptr_next;
  logic [LEN_W-1:0]  ptr_dest;
  logic              ptr_last;
  always_comb begin
    ptr_next = (op == ACT_INSERT) ? ptr - LEN_W'(1) : ptr + LEN_W'(1);
    ptr_dest = (op == ACT_INSERT) ? ptr + LEN_W'(1) : ptr - LEN_W'(1);
    ptr_last = (ptr == end_ptr);
  end

  // Cursor move target and range check
  logic signed [MOV_W-1:0] target;
  logic                    move_ok;
  always_comb begin
    target  = $signed(MOV_W'(cursor)) + MOV_W'(ev.cursor_step);
    move_ok = (ev.cursor_step != 9'sd0) && !target[MOV_W-1]
              && (target <= $signed(MOV_W'(fill_len)));
  end

  // Read index bound
  logic rd_ok;
  assign rd_ok = CMP_W'(ev.read_index) < CMP_W'(fill_len);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill_len <= '0;
      cursor   <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ev_valid) begin
            op     <= ev.action;
            ch     <= ev.char_code;
            rchar  <= 8'd0;
            status <= ST_DONE;
            case (ev.action)
              ACT_INSERT: begin
                if (fill_len == LEN_W'(STORE_DEPTH)) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else if (cursor == fill_len) begin
                  state <= S_PUT;
                end else begin
                  ptr     <= fill_len - LEN_W'(1);
                  end_ptr <= cursor;
                  state   <= S_SHIFT;
                end
              end
              ACT_BACKSPACE: begin
                if (cursor == '0) begin
                  status <= ST_NONE;
                  state  <= S_DONE;
                end else if (cursor == fill_len) begin
                  fill_len <= fill_len - LEN_W'(1);
                  cursor   <= cursor - LEN_W'(1);
                  state    <= S_DONE;
                end else begin
                  ptr     <= cursor;
                  end_ptr <= fill_len - LEN_W'(1);
                  state   <= S_SHIFT;
                end
              end
              ACT_MOVE: begin
                if (move_ok) begin
                  cursor <= LEN_W'(target);
                end else begin
                  status <= ST_NONE;
                end
                state <= S_DONE;
              end
              default: begin
                if (rd_ok) begin
                  ptr   <= LEN_W'(ev.read_index);
                  state <= S_RDREQ;
                end else begin
                  status <= ST_NONE;
                  state  <= S_DONE;
                end
              end
            endcase
          end
        end
        // Read one byte, write it back one place over on the next cycle
        S_SHIFT: begin
          pend      <= 1'b1;
          pend_addr <= ptr_dest[ADDR_W-1:0];
          if (ptr_last) begin
            state <= S_DRAIN;
          end else begin
            ptr <= ptr_next;
          end
        end
        // Last shifted byte lands in this cycle
        S_DRAIN: begin
          if (op == ACT_INSERT) begin
            state <= S_PUT;
          end else begin
            fill_len <= fill_len - LEN_W'(1);
            cursor   <= cursor - LEN_W'(1);
            state    <= S_DONE;
          end
        end
        S_PUT: begin
          fill_len <= fill_len + LEN_W'(1);
          cursor   <= cursor + LEN_W'(1);
          state    <= S_DONE;
        end
        S_RDREQ: begin
          state <= S_RDWAIT;
        end
        S_RDWAIT: begin
          rchar <= ram_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Store port drive: pending shift write wins, else the inserted byte
  always_comb begin
    ram_we    = pend || (state == S_PUT);
    ram_waddr = pend ? pend_addr : cursor[ADDR_W-1:0];
    ram_wdata = pend ? ram_rdata : ch;
    ram_raddr = ptr[ADDR_W-1:0];
  end

  // Handshake and result record
  assign ev_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  always_comb begin
    res.status      = status;
    res.text_length = 8'(fill_len);
    res.cursor_pos  = 8'(cursor);
    res.read_char   = rchar;
  end

endmodule : cebuf_seq
`default_nettype wire

FILE: hw/rtl/cursor_edit_buffer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_edit_buffer_core
// Line edit buffer: a byte store with fill length and cursor, taking insert,
// backspace, cursor move and read events, one result per event.
// ----------------------------------------------------------------------------
//  Channel   Dir  Width  Fields (lowest bit up)
//  s_axis    in   32     action[1:0] char_code[9:2] cursor_step[18:10]
//                        read_index[25:19]
//  m_axis    out  32     status[1:0] text_length[9:2] cursor_pos[17:10]
//                        read_char[25:18]
//
//  Insert and backspace with text after the cursor shift that text over the
//  store's single write port, one byte per cycle; at the end of the text
//  no shift is needed. Read, move and rejected events need no shift walk.
//  One event is in work at a time; the next is taken once the result has
//  moved to the output register. Reset clears length and cursor; store
//  contents stay undefined until written. A stalled output holds its
//  result and the sequencer waits to hand over the next one.
// ----------------------------------------------------------------------------
module cursor_edit_buffer_core #(
  parameter int STORE_DEPTH = cebuf_pkg::STORE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Event stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // action, char_code, cursor_step, read_index
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata   // status, text_length, cursor_pos, read_char
);

  import cebuf_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  event_t            ev;
  result_t           res;
  result_t           out_res;
  logic              res_valid;
  logic              res_ready;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Unpack the event
  always_comb begin
    ev.action      = action_t'(s_tdata[1:0]);
    ev.char_code   = s_tdata[9:2];
    ev.cursor_step = $signed(s_tdata[18:10]);
    ev.read_index  = s_tdata[25:19];
  end

  cebuf_seq #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (s_tvalid),
    .ev_ready  (s_tready),
    .ev        (ev),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  cebuf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: load when empty or its transfer completes
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.read_char, out_res.cursor_pos,
                    out_res.text_length, out_res.status};

endmodule : cursor_edit_buffer_core
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cursor edit buffer. A queue of edit events,
// directed first and then random runs that fill and drain the store, feeds a
// bursty stream driver. Each accepted transfer updates a local copy of text,
// length and cursor that yields the expected result, and a monitor behind a
// stalling receiver compares every returned result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import cebuf_pkg::*;

  localparam int DEPTH      = STORE_DEPTH_DEF;
  localparam int RAND_ITEMS = 1450;

  // Event plus a flag to hold it back until all results are in
  typedef struct {
    event_t ev;
    bit     drain_first;
  } edit_item_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  edit_item_t stim_items[$];
  result_t    pending_results[$];

  // Local copy of the buffer, updated per accepted event
  logic [7:0] shadow_text [DEPTH];
  int         shadow_len = 0;
  int         shadow_cur = 0;

  // Length and cursor as the stimulus builder expects them
  int gen_len = 0;
  int gen_cur = 0;

  int n_acc     = 0;
  int n_res     = 0;
  int err_count = 0;
  int total_items;

  // Sender pacing
  int burst_left = 8;
  int gap_left   = 0;

  // Receiver pacing
  int rx_mode   = 0;
  int rx_left   = 64;
  int rx_tick   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  cursor_edit_buffer_core #(
    .STORE_DEPTH (DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      flag_error($sformatf("result %0d %s got %0d want %0d", n_res, name, got, want));
    end
  endtask

  // Apply one event to the local buffer and return the result it must give
  function automatic result_t predict_edit(input event_t ev);
    result_t r;
    int      stp;
    int      tgt;
    r        = '0;
    r.status = ST_DONE;
    case (ev.action)
      ACT_INSERT: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > shadow_cur; i--) shadow_text[i] = shadow_text[i-1];
          shadow_text[shadow_cur] = ev.char_code;
          shadow_cur++;
          shadow_len++;
        end
      end
      ACT_BACKSPACE: begin
        if (shadow_cur == 0) begin
          r.status = ST_NONE;
        end else begin
          for (int i = shadow_cur; i < shadow_len; i++) shadow_text[i-1] = shadow_text[i];
          shadow_len--;
          shadow_cur--;
        end
      end
      ACT_MOVE: begin
        stp = $signed(ev.cursor_step);
        tgt = shadow_cur + stp;
        if (stp == 0 || tgt < 0 || tgt > shadow_len) r.status = ST_NONE;
        else shadow_cur = tgt;
      end
      default: begin
        if (int'(ev.read_index) < shadow_len) r.read_char = shadow_text[ev.read_index];
        else r.status = ST_NONE;
      end
    endcase
    r.text_length = shadow_len[7:0];
    r.cursor_pos  = shadow_cur[7:0];
    return r;
  endfunction

  // Queue one event; fields the action ignores carry random noise
  task automatic push_event(input action_t act, input int ch, input int stp, input int idx,
                            input bit hold = 1'b0);
    edit_item_t it;
    int         tgt;
    it.ev.action      = act;
    it.ev.char_code   = (act == ACT_INSERT) ? ch[7:0] : 8'($urandom);
    it.ev.cursor_step = (act == ACT_MOVE) ? stp[8:0] : 9'($urandom);
    it.ev.read_index  = (act == ACT_READ) ? idx[6:0] : 7'($urandom);
    it.drain_first    = hold;
    stim_items.push_back(it);
    // track length and cursor so later items can aim inside the text
    case (act)
      ACT_INSERT: if (gen_len < DEPTH) begin
        gen_len++;
        gen_cur++;
      end
      ACT_BACKSPACE: if (gen_cur > 0) begin
        gen_len--;
        gen_cur--;
      end
      ACT_MOVE: begin
        tgt = gen_cur + stp;
        if (stp != 0 && tgt >= 0 && tgt <= gen_len) gen_cur = tgt;
      end
      default: ;
    endcase
  endtask

  // Mixed editing, mostly well aimed, some out of range
  task automatic mixed_run(input int n, input bit hold);
    int r;
    int stp;
    int idx;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_event(ACT_INSERT, $urandom_range(0, 255), 0, 0, hold && k == 0);
      end else if (r < 55) begin
        push_event(ACT_BACKSPACE, 0, 0, 0, hold && k == 0);
      end else if (r < 80) begin
        if ($urandom_range(0, 4) != 0) stp = int'($urandom_range(0, gen_len)) - gen_cur;
        else stp = int'($urandom_range(0, 256)) - 128;
        push_event(ACT_MOVE, 0, stp, 0, hold && k == 0);
      end else begin
        if (gen_len > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, gen_len - 1);
        else idx = $urandom_range(0, 127);
        push_event(ACT_READ, 0, 0, idx, hold && k == 0);
      end
    end
  endtask

  // Fill past full, sweep the cursor end to end, read back, then drain
  task automatic fill_drain_run();
    int n;
    n = DEPTH - gen_len + $urandom_range(1, 5);
    for (int k = 0; k < n; k++) push_event(ACT_INSERT, $urandom_range(0, 255), 0, 0);
    push_event(ACT_MOVE, 0, gen_len - gen_cur, 0);
    push_event(ACT_MOVE, 0, -gen_cur, 0);
    push_event(ACT_MOVE, 0, gen_len, 0);
    for (int k = 0; k < 20; k++) push_event(ACT_READ, 0, 0, $urandom_range(0, 127));
    push_event(ACT_MOVE, 0, int'($urandom_range(0, gen_len)) - gen_cur, 0);
    n = gen_cur + 2;
    for (int k = 0; k < n; k++) push_event(ACT_BACKSPACE, 0, 0, 0);
    push_event(ACT_MOVE, 0, gen_len - gen_cur, 0);
    n = gen_len + 1;
    for (int k = 0; k < n; k++) push_event(ACT_BACKSPACE, 0, 0, 0);
  endtask

  // Stimulus, end of run and verdict
  initial begin
    int round;
    int start_cnt;
    // directed: empty buffer edge cases, extremes of every field
    push_event(ACT_READ, 0, 0, 0);
    push_event(ACT_BACKSPACE, 0, 0, 0);
    push_event(ACT_MOVE, 0, 0, 0);
    push_event(ACT_MOVE, 0, -1, 0);
    push_event(ACT_MOVE, 0, 1, 0);
    push_event(ACT_INSERT, 8'h00, 0, 0);
    push_event(ACT_INSERT, 8'hFF, 0, 0);
    push_event(ACT_INSERT, 8'hA5, 0, 0);
    push_event(ACT_MOVE, 0, -2, 0);
    push_event(ACT_INSERT, 8'h5A, 0, 0);
    for (int k = 0; k < 4; k++) push_event(ACT_READ, 0, 0, k);
    push_event(ACT_READ, 0, 0, 127);
    push_event(ACT_MOVE, 0, 128, 0);
    push_event(ACT_MOVE, 0, -128, 0);
    push_event(ACT_BACKSPACE, 0, 0, 0);
    push_event(ACT_MOVE, 0, 2, 0);
    push_event(ACT_READ, 0, 0, 2);
    push_event(ACT_BACKSPACE, 0, 0, 0);
    push_event(ACT_MOVE, 0, -1, 0);
    // random: mixed runs with a fill and drain every fourth round
    start_cnt = stim_items.size();
    round     = 0;
    while (stim_items.size() - start_cnt < RAND_ITEMS) begin
      if (round % 4 == 3) fill_drain_run();
      else mixed_run($urandom_range(20, 60), round == 2 || $urandom_range(0, 3) == 0);
      round++;
    end
    total_items = stim_items.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (n_acc == total_items && n_res == total_items);
    repeat (DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Driver: offer events in bursts, predict on each accepted transfer
  always @(posedge clk) begin
    logic       fire;
    edit_item_t it;
    int         g;
    fire = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (fire) begin
        pending_results.push_back(predict_edit(event_t'(s_tdata[25:0])));
        n_acc <= n_acc + 1;
      end
      if (fire || !s_tvalid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (stim_items.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (stim_items[0].drain_first && (fire || n_acc != n_res)) begin
          // hold off until every result is back
          s_tvalid <= 1'b0;
        end else begin
          it       = stim_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, it.ev};
          if (burst_left <= 1) begin
            g          = $urandom_range(0, 9);
            burst_left <= $urandom_range(1, 24);
            gap_left   <= (g < 5) ? 0 :
                          (g < 8) ? $urandom_range(1, 4) :
                          (g < 9) ? $urandom_range(5, 40) : $urandom_range(100, 150);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Monitor: stall the result stream and compare each transfer
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[25:0];
        if (n_res >= n_acc) begin
          flag_error($sformatf("unexpected result %h", m_tdata));
        end else begin
          want = pending_results.pop_front();
          check_field("status", got.status, want.status);
          check_field("text_length", got.text_length, want.text_length);
          check_field("cursor_pos", got.cursor_pos, want.cursor_pos);
          check_field("read_char", got.read_char, want.read_char);
          n_res <= n_res + 1;
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (!hold_done && n_res >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        m_tready  <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 9) < 7);
          2:       m_tready <= (rx_tick % 3 == 0);
          default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
          rx_mode <= $urandom_range(0, 3);
          rx_left <= $urandom_range(32, 256);
        end else begin
          rx_left <= rx_left - 1;
        end
      end
    end
  end

endmodule
